// ===== rtl/tmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcw_pkg: shared types and constants of the text-mode console writer
// Request codes, decoded operations, the queue command record, the engine
// state type and the fixed field widths of the request and response ports.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    // Port field widths
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 11;
    localparam int CELL_W = 16;
    localparam int CLR_W  = 4;

    // Request type codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Character codes with special handling
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7F;

    localparam int TAB_STOP = 8;

    // Blank cell: white on black space
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    // Configuration register indexes
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    // Operation decoded by the front end
    typedef enum logic [2:0] {
        OP_PUT,
        OP_BS,
        OP_TAB,
        OP_CR,
        OP_LF,
        OP_NOP,
        OP_CLEAR,
        OP_READ
    } op_t;

    // Queue entry between front and back
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] chr;
        logic [IDX_W-1:0]  idx;
    } cmd_t;

    // Back-end engine states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } eng_state_t;

endpackage

// ===== rtl/tmcw_front.sv =====
// ----------------------------------------------------------------------------
// tmcw_front: request intake and classification
// Decodes each request into an operation and holds it in a two-entry
// queue that the execution engine drains.
// ----------------------------------------------------------------------------
module tmcw_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [tmcw_pkg::REQ_W-1:0]  req_type,
    input  logic [tmcw_pkg::CHAR_W-1:0] char_code,
    input  logic [tmcw_pkg::IDX_W-1:0]  cell_index,
    input  logic                        hold,
    output logic                        q_valid,
    output tmcw_pkg::cmd_t              q_cmd,
    input  logic                        q_pop
);
    import tmcw_pkg::*;

    cmd_t       fifo_reg [2];
    cmd_t       cmd_in;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    // Classify the request
    always_comb
    begin
        cmd_in.chr = char_code;
        cmd_in.idx = cell_index;
        cmd_in.op  = OP_NOP;
        unique case (req_type)
            REQ_PUT:
            begin
                unique case (char_code) inside
                    CH_BS:                     cmd_in.op = OP_BS;
                    CH_TAB:                    cmd_in.op = OP_TAB;
                    CH_CR:                     cmd_in.op = OP_CR;
                    CH_LF:                     cmd_in.op = OP_LF;
                    [CH_PRINT_LO:CH_PRINT_HI]: cmd_in.op = OP_PUT;
                    default:                   cmd_in.op = OP_NOP;
                endcase
            end
            REQ_CLEAR: cmd_in.op = OP_CLEAR;
            REQ_READ:  cmd_in.op = OP_READ;
            default:   cmd_in.op = OP_NOP;
        endcase
    end

    // Queue control
    assign req_ready = (count_reg != 2'd2) && !hold;
    assign push      = req_valid && req_ready;
    assign q_valid   = (count_reg != 2'd0);
    assign q_cmd     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/tmcw_back.sv =====
// ----------------------------------------------------------------------------
// tmcw_back: console execution engine
// Holds the cursor, the cell store and the attribute registers; runs the
// power-up clear, screen clear and scroll sweeps and registers the response.
// ----------------------------------------------------------------------------
module tmcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [tmcw_pkg::CLR_W-1:0]  cfg_data,
    input  logic                        q_valid,
    input  tmcw_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        init_busy,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [tmcw_pkg::COL_W-1:0]  cursor_col,
    output logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
    output logic [tmcw_pkg::OFF_W-1:0]  cursor_offset,
    output logic [tmcw_pkg::CELL_W-1:0] cell_value,
    output logic                        scrolled
);
    import tmcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(COLUMNS);
    localparam int YW    = $clog2(ROWS);
    localparam logic [AW-1:0] LAST_CELL      = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_ROW_START = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A         = AW'(COLUMNS);

    eng_state_t state_reg, state_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic          scr_reg, scr_next;
    logic [CLR_W-1:0] fg_reg, bg_reg;

    // Cell store
    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_wa, mem_ra;
    logic [CELL_W-1:0] mem_wd;

    // Response register
    logic              rsp_valid_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [CELL_W-1:0] cell_reg;
    logic              scr_out_reg;

    logic              slot_free, emit, emit_scr, adv;
    logic [CELL_W-1:0] emit_cell;
    logic [7:0]        x_t;
    logic [YW:0]       y_t;
    logic [AW-1:0]     base_t;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign init_busy = (state_reg == ST_INIT);

    // Engine next state, cursor update and store access
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        base_next  = base_reg;
        scan_next  = scan_reg;
        scr_next   = scr_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = scan_reg;
        mem_wd     = BLANK_CELL;
        mem_ra     = AW'(q_cmd.idx);
        emit       = 1'b0;
        emit_cell  = '0;
        emit_scr   = 1'b0;
        adv        = 1'b0;
        x_t        = 8'(x_reg);
        y_t        = (YW+1)'(y_reg);
        base_t     = base_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we = 1'b1;
                if (scan_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                    scan_next  = '0;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    unique case (q_cmd.op)
                        OP_PUT:
                        begin
                            mem_we = 1'b1;
                            mem_wa = base_reg + AW'(x_reg);
                            mem_wd = {bg_reg, fg_reg, q_cmd.chr};
                            x_t    = x_t + 8'd1;
                        end
                        OP_BS:
                        begin
                            if (x_reg != '0)
                            begin
                                mem_we = 1'b1;
                                mem_wa = base_reg + AW'(x_reg) - AW'(1);
                                x_t    = x_t - 8'd1;
                            end
                        end
                        OP_TAB: x_t = (x_t + 8'(TAB_STOP)) & ~8'(TAB_STOP - 1);
                        OP_CR:  x_t = '0;
                        OP_LF:
                        begin
                            x_t = '0;
                            adv = 1'b1;
                        end
                        OP_NOP: ;
                        OP_CLEAR:
                        begin
                            emit       = 1'b0;
                            state_next = ST_FILL;
                            scan_next  = '0;
                            scr_next   = 1'b0;
                        end
                        OP_READ:
                        begin
                            // out-of-range index answers zero at once
                            if (32'(q_cmd.idx) < 32'(CELLS))
                            begin
                                emit       = 1'b0;
                                state_next = ST_READ;
                            end
                        end
                    endcase
                    // column wrap
                    if (x_t >= 8'(COLUMNS))
                    begin
                        x_t = '0;
                        adv = 1'b1;
                    end
                    if (adv)
                    begin
                        y_t    = y_t + (YW+1)'(1);
                        base_t = base_reg + COLS_A;
                    end
                    // past the last row: scroll, cursor stays on last row
                    if (y_t == (YW+1)'(ROWS))
                    begin
                        y_t        = (YW+1)'(ROWS - 1);
                        base_t     = base_reg;
                        emit       = 1'b0;
                        state_next = ST_SCROLL;
                        scan_next  = '0;
                        scr_next   = 1'b1;
                    end
                    x_next    = XW'(x_t);
                    y_next    = YW'(y_t);
                    base_next = base_t;
                end
            end
            ST_READ:
            begin
                emit       = 1'b1;
                emit_cell  = rd_data_reg;
                state_next = ST_IDLE;
            end
            ST_SCROLL:
            begin
                // read source one row down, write it back in the next cycle
                if (scan_reg != LAST_ROW_START)
                begin
                    mem_ra = scan_reg + COLS_A;
                end
                if (scan_reg != '0)
                begin
                    mem_we = 1'b1;
                    mem_wa = scan_reg - AW'(1);
                    mem_wd = rd_data_reg;
                end
                if (scan_reg == LAST_ROW_START)
                begin
                    state_next = ST_FILL;
                    scan_next  = LAST_ROW_START;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            ST_FILL:
            begin
                mem_we = 1'b1;
                if (scan_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                    scan_next  = '0;
                    emit       = 1'b1;
                    emit_scr   = scr_reg;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Engine registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            x_reg     <= '0;
            y_reg     <= '0;
            base_reg  <= '0;
            scan_reg  <= '0;
            scr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            base_reg  <= base_next;
            scan_reg  <= scan_next;
            scr_reg   <= scr_next;
        end
    end

    // Attribute registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= 4'hF;
            bg_reg <= 4'h0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_FG:  fg_reg <= cfg_data;
                CFG_BG:  bg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Cell store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            col_reg     <= COL_W'(x_next);
            row_reg     <= ROW_W'(y_next);
            off_reg     <= OFF_W'(base_next + AW'(x_next));
            cell_reg    <= emit_cell;
            scr_out_reg <= emit_scr;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign cursor_col    = col_reg;
    assign cursor_row    = row_reg;
    assign cursor_offset = off_reg;
    assign cell_value    = cell_reg;
    assign scrolled      = scr_out_reg;

    // A response never overwrites one still waiting
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> slot_free)
        else $error("response loaded while previous one pending");

    // Cursor stays on screen between requests
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (32'(x_reg) < 32'(COLUMNS) && 32'(y_reg) < 32'(ROWS)))
        else $error("cursor off screen");

    // During a scroll the cursor sits on the last row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) |-> (y_reg == YW'(ROWS - 1)))
        else $error("scroll with cursor not on last row");

endmodule

// ===== rtl/text_mode_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_mode_console_writer_core: text-mode console engine
// Requests (req_valid/req_ready) carry put-char, clear and read-cell
// operations; one response (rsp_valid/rsp_ready) per request gives the
// cursor, its linear offset, the read cell and a scroll flag. Attribute
// colors are written through cfg_wr_en/cfg_index/cfg_data; the user must
// write them only while idle, which the block does not enforce. Responses
// are registered; a read also passes the registered store read. Clear and
// a put-char that scrolls sweep the store, set by the single write port of
// the cell store, one cell per cycle. Other requests, in-range reads apart,
// sustain one per cycle while rsp_ready is high. After reset the store is
// blanked cell by cell, during which req_ready stays low. A two-entry queue
// sits between intake and engine; when rsp_ready is low the engine holds
// the result, the queue fills and req_ready drops.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [tmcw_pkg::CLR_W-1:0]  cfg_data,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [tmcw_pkg::REQ_W-1:0]  req_type,
    input  logic [tmcw_pkg::CHAR_W-1:0] char_code,
    input  logic [tmcw_pkg::IDX_W-1:0]  cell_index,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [tmcw_pkg::COL_W-1:0]  cursor_col,
    output logic [tmcw_pkg::ROW_W-1:0]  cursor_row,
    output logic [tmcw_pkg::OFF_W-1:0]  cursor_offset,
    output logic [tmcw_pkg::CELL_W-1:0] cell_value,
    output logic                        scrolled
);
    import tmcw_pkg::*;

    logic q_valid, q_pop, init_busy;
    cmd_t q_cmd;

    // Intake and classification
    tmcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .char_code  (char_code),
        .cell_index (cell_index),
        .hold       (init_busy),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop)
    );

    // Execution engine
    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .init_busy     (init_busy),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value),
        .scrolled      (scrolled)
    );

endmodule

// ===== tb/text_mode_console_writer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_core_test: self-checking bench for the console core
// Drives put-char, clear, read and unused requests with random gaps on both
// handshakes, tracks the screen store, cursor and colors in a scoreboard and
// compares every response field. Colors are rewritten between idle phases.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core_test;
    import tmcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int CLK_PERIOD  = 20;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 313;
    localparam int DRAIN_LIMIT = 100000;
    // worst case: every request scrolls and meets the longest gap and stall
    localparam longint unsigned TIMEOUT_NS = 64'd400_000_000;

    // request type with no operation behind it
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } console_req_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [OFF_W-1:0]  offset;
        logic [CELL_W-1:0] cell_val;
        logic              scrolled;
    } cursor_report_t;

    // ------------------------------------------------------------------------
    // Scoreboard: screen store, cursor and colors plus the responses still owed
    // ------------------------------------------------------------------------
    class console_scoreboard;
        localparam int unsigned PRINT_CAP = 50;

        logic [CELL_W-1:0] cells [CELLS];
        int unsigned       col;
        int unsigned       row;
        logic [CLR_W-1:0]  fg;
        logic [CLR_W-1:0]  bg;
        cursor_report_t    owed_reports [$];
        int unsigned       errors;

        function new();
            blank_cells(0, CELLS);
            col    = 0;
            row    = 0;
            fg     = 4'hF;
            bg     = 4'h0;
            errors = 0;
        endfunction

        function void blank_cells(int unsigned first, int unsigned count);
            for (int unsigned i = first; i < first + count; i++)
                cells[i] = BLANK_CELL;
        endfunction

        function int unsigned pending();
            return owed_reports.size();
        endfunction

        // one printed line per mismatch, printing capped to keep the log short
        task report_mismatch(input string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // returns 1 when the cursor ran off the bottom and the store scrolled
        function bit put_char(logic [CHAR_W-1:0] ch);
            if (ch == CH_BS) begin
                if (col != 0) begin
                    col--;
                    cells[row * COLUMNS + col] = BLANK_CELL;
                end
            end
            else if (ch == CH_TAB)
                col = (col + TAB_STOP) & ~(TAB_STOP - 1);
            else if (ch == CH_CR)
                col = 0;
            else if (ch == CH_LF) begin
                col = 0;
                row++;
            end
            else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
                cells[row * COLUMNS + col] = {bg, fg, ch};
                col++;
            end
            if (col >= COLUMNS) begin
                col = 0;
                row++;
            end
            if (row < ROWS)
                return 1'b0;
            for (int i = 0; i < CELLS - COLUMNS; i++)
                cells[i] = cells[i + COLUMNS];
            blank_cells(CELLS - COLUMNS, COLUMNS);
            row = ROWS - 1;
            return 1'b1;
        endfunction

        // accepted request: update the store and queue the response it owes
        function void log_request(console_req_t r);
            cursor_report_t rep;
            int unsigned    off;
            rep.cell_val = '0;
            rep.scrolled = 1'b0;
            case (r.kind)
                REQ_PUT:   rep.scrolled = put_char(r.ch);
                REQ_CLEAR: blank_cells(0, CELLS);
                REQ_READ:  if (r.idx < CELLS) rep.cell_val = cells[r.idx];
                default:   ;
            endcase
            off        = row * COLUMNS + col;
            rep.col    = col[COL_W-1:0];
            rep.row    = row[ROW_W-1:0];
            rep.offset = off[OFF_W-1:0];
            owed_reports.push_back(rep);
        endfunction

        task check_response(input cursor_report_t got);
            cursor_report_t want;
            if (owed_reports.size() == 0) begin
                report_mismatch("response with no request outstanding");
                return;
            end
            want = owed_reports.pop_front();
            if (got.col !== want.col)
                report_mismatch($sformatf("cursor_col got %0d want %0d", got.col, want.col));
            if (got.row !== want.row)
                report_mismatch($sformatf("cursor_row got %0d want %0d", got.row, want.row));
            if (got.offset !== want.offset)
                report_mismatch($sformatf("cursor_offset got %0d want %0d",
                                          got.offset, want.offset));
            if (got.cell_val !== want.cell_val)
                report_mismatch($sformatf("cell_value got %h want %h",
                                          got.cell_val, want.cell_val));
            if (got.scrolled !== want.scrolled)
                report_mismatch($sformatf("scrolled got %b want %b",
                                          got.scrolled, want.scrolled));
        endtask
    endclass

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_wr_en  = 1'b0;
    logic               cfg_index  = CFG_FG;
    logic [CLR_W-1:0]   cfg_data   = '0;
    logic               req_valid  = 1'b0;
    logic               req_ready;
    logic [REQ_W-1:0]   req_type   = REQ_PUT;
    logic [CHAR_W-1:0]  char_code  = '0;
    logic [IDX_W-1:0]   cell_index = '0;
    logic               rsp_valid;
    logic               rsp_ready  = 1'b0;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [OFF_W-1:0]   cursor_offset;
    logic [CELL_W-1:0]  cell_value;
    logic               scrolled;

    console_scoreboard sb = new();

    text_mode_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .char_code     (char_code),
        .cell_index    (cell_index),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cursor_offset (cursor_offset),
        .cell_value    (cell_value),
        .scrolled      (scrolled)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // any byte, any 11-bit index
    function automatic logic [CHAR_W-1:0] any_char();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [IDX_W-1:0] any_idx();
        return IDX_W'($urandom_range(0, 2047));
    endfunction

    function automatic console_req_t make_req(logic [REQ_W-1:0] kind,
                                              logic [CHAR_W-1:0] ch,
                                              logic [IDX_W-1:0] idx);
        console_req_t r;
        r.kind = kind;
        r.ch   = ch;
        r.idx  = idx;
        return r;
    endfunction

    // random request: mostly text, with line control, reads and rare clears
    function automatic console_req_t pick_request();
        console_req_t r;
        int unsigned  sel;
        int unsigned  here;
        int unsigned  back;
        r.kind = REQ_PUT;
        r.ch   = any_char();
        r.idx  = any_idx();
        sel    = $urandom_range(0, 999);
        if (sel < 690)
            r.ch = CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        else if (sel < 740)
            r.ch = CH_LF;
        else if (sel < 770)
            r.ch = CH_CR;
        else if (sel < 810)
            r.ch = CH_BS;
        else if (sel < 850)
            r.ch = CH_TAB;
        else if (sel < 880)
            r.ch = CHAR_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(128, 255));
        else if (sel < 890)
            r.kind = REQ_CLEAR;
        else if (sel < 975) begin
            r.kind = REQ_READ;
            sel    = $urandom_range(0, 9);
            // read just behind the cursor most of the time, to see fresh text
            if (sel < 6) begin
                here  = sb.row * COLUMNS + sb.col;
                back  = $urandom_range(0, 100);
                r.idx = IDX_W'((here >= back) ? here - back : here);
            end
            else if (sel < 9)
                r.idx = IDX_W'($urandom_range(0, CELLS - 1));
            else
                r.idx = IDX_W'($urandom_range(CELLS, 2047));
        end
        else
            r.kind = REQ_UNUSED;
        return r;
    endfunction

    // hold the request until accepted, then log it
    task automatic send_request(input console_req_t r);
        req_valid  <= 1'b1;
        req_type   <= r.kind;
        char_code  <= r.ch;
        cell_index <= r.idx;
        do
            @(posedge clk);
        while (!req_ready);
        sb.log_request(r);
    endtask

    task automatic issue(input console_req_t r, input bit calm);
        int unsigned gap;
        send_request(r);
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every owed response come back
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_colors(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FG;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= CFG_BG;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.fg = fg;
        sb.bg = bg;
        @(posedge clk);
    endtask

    // response check on every accepted response
    always @(posedge clk)
    begin
        cursor_report_t got;
        if (rst_n && rsp_valid && rsp_ready) begin
            got.col      = cursor_col;
            got.row      = cursor_row;
            got.offset   = cursor_offset;
            got.cell_val = cell_value;
            got.scrolled = scrolled;
            sb.check_response(got);
        end
    end

    // response side back-pressure
    initial
    begin
        int unsigned run;
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            rsp_ready <= 1'b1;
            run = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall != 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // main sequence
    initial
    begin
        logic [CLR_W-1:0] fg_plan [PHASES];
        logic [CLR_W-1:0] bg_plan [PHASES];
        bit               calm;
        int               drain;

        fg_plan = '{4'h0, 4'hF, 4'h0, 4'h0, 4'h0, 4'hF};
        bg_plan = '{4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0};
        fg_plan[3] = CLR_W'($urandom_range(0, 15));
        bg_plan[3] = CLR_W'($urandom_range(0, 15));
        fg_plan[4] = CLR_W'($urandom_range(0, 15));
        bg_plan[4] = CLR_W'($urandom_range(0, 15));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        set_colors(4'h7, 4'h1);

        // directed: printable extremes, backspace, ignored bytes, reads
        issue(make_req(REQ_PUT, CH_PRINT_LO, any_idx()), 1'b0);
        issue(make_req(REQ_PUT, CH_PRINT_HI, any_idx()), 1'b0);
        issue(make_req(REQ_READ, any_char(), 11'd1), 1'b0);
        issue(make_req(REQ_PUT, CH_BS, any_idx()), 1'b0);
        issue(make_req(REQ_PUT, CH_BS, any_idx()), 1'b0);
        // backspace in column 0 does nothing
        issue(make_req(REQ_PUT, CH_BS, any_idx()), 1'b0);
        issue(make_req(REQ_PUT, 8'h00, 11'h7FF), 1'b0);
        issue(make_req(REQ_PUT, 8'h1F, 11'h000), 1'b0);
        issue(make_req(REQ_PUT, 8'h80, 11'h555), 1'b0);
        issue(make_req(REQ_PUT, 8'hFF, 11'h2AA), 1'b0);
        issue(make_req(REQ_READ, any_char(), 11'd0), 1'b0);
        issue(make_req(REQ_READ, any_char(), IDX_W'(CELLS - 1)), 1'b0);
        // reads past the store give zero
        issue(make_req(REQ_READ, any_char(), IDX_W'(CELLS)), 1'b0);
        issue(make_req(REQ_READ, any_char(), 11'h7FF), 1'b0);
        issue(make_req(REQ_UNUSED, any_char(), any_idx()), 1'b0);
        issue(make_req(REQ_PUT, 8'h41, any_idx()), 1'b0);
        issue(make_req(REQ_PUT, CH_CR, any_idx()), 1'b0);
        issue(make_req(REQ_PUT, CH_LF, any_idx()), 1'b0);
        // tab stops across the row; the last one wraps to the next row
        repeat (10)
            issue(make_req(REQ_PUT, CH_TAB, any_idx()), 1'b0);
        issue(make_req(REQ_CLEAR, any_char(), any_idx()), 1'b0);
        issue(make_req(REQ_READ, any_char(), 11'd0), 1'b0);

        // random phases, colors changed only while idle
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            set_colors(fg_plan[p], bg_plan[p]);
            calm = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 4) == 0);
                issue(pick_request(), calm);
            end
        end

        // drain
        req_valid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // hard stop if the run hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
